@@ hdl/clcd_pkg.sv @@
package clcd_pkg;

  // microcode address and entry points
  localparam int unsigned UcAddrW = 6;
  localparam logic [UcAddrW-1:0] EntryInit = 6'd0;
  localparam logic [UcAddrW-1:0] EntryByte = 6'd37;
  localparam logic [UcAddrW-1:0] StepLastClear = 6'd43;

  // display command bytes and cursor limits
  localparam logic [7:0] CmdClear    = 8'h01;
  localparam logic [7:0] CmdSetDdram = 8'h80;
  localparam logic [7:0] RowOffset   = 8'h40;
  localparam logic [7:0] ColMax      = 8'd15;

  // request codes
  typedef enum logic [1:0] {
    REQ_INIT   = 2'd0,
    REQ_CLEAR  = 2'd1,
    REQ_CURSOR = 2'd2,
    REQ_CHAR   = 2'd3
  } clcd_req_e;

  // where the data nibble of a write comes from
  typedef enum logic [1:0] {
    NIB_CONST = 2'd0,
    NIB_OP_HI = 2'd1,
    NIB_OP_LO = 2'd2
  } clcd_nib_src_e;

  // wait after a write
  typedef enum logic [2:0] {
    WAIT_SHORT = 3'd0,
    WAIT_EXEC  = 3'd1,
    WAIT_CMD   = 3'd2,
    WAIT_CLEAR = 3'd3,
    WAIT_WAKE  = 3'd4,
    WAIT_POWER = 3'd5
  } clcd_wait_e;

  // one control word of the program
  typedef struct packed {
    clcd_nib_src_e               nib_src;
    logic [3:0]                  nib;
    logic                        en;
    clcd_wait_e                  wait_sel;
    logic                        last;
    logic                        jmp_clear;
    logic [UcAddrW-1:0]          jmp_tgt;
  } clcd_uword_t;

  // wait code to microseconds
  function automatic logic [15:0] wait_us(clcd_wait_e code);
    logic [15:0] us;
    unique case (code)
      WAIT_SHORT: us = 16'd1;
      WAIT_EXEC:  us = 16'd50;
      WAIT_CMD:   us = 16'd1050;
      WAIT_CLEAR: us = 16'd2050;
      WAIT_WAKE:  us = 16'd5050;
      WAIT_POWER: us = 16'd50000;
      default:    us = 16'd1;
    endcase
    return us;
  endfunction

  // control word builder
  function automatic clcd_uword_t uw(clcd_nib_src_e src, logic [3:0] nib, logic en,
                                     clcd_wait_e wt, logic last, logic jmp,
                                     logic [UcAddrW-1:0] tgt);
    clcd_uword_t w;
    w.nib_src   = src;
    w.nib       = nib;
    w.en        = en;
    w.wait_sel  = wt;
    w.last      = last;
    w.jmp_clear = jmp;
    w.jmp_tgt   = tgt;
    return w;
  endfunction

endpackage

@@ hdl/clcd_req_if.sv @@
interface clcd_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] column;
  logic [7:0] row_index;
  logic [7:0] char_code;

  modport source (output valid, req_type, column, row_index, char_code, input ready);
  modport sink   (input valid, req_type, column, row_index, char_code, output ready);
endinterface

@@ hdl/clcd_wr_if.sv @@
interface clcd_wr_if;
  logic        valid;
  logic        ready;
  logic [7:0]  expander_byte;
  logic [6:0]  target_address;
  logic [15:0] wait_after_us;
  logic        last_write;

  modport source (output valid, expander_byte, target_address, wait_after_us, last_write,
                  input ready);
  modport sink   (input valid, expander_byte, target_address, wait_after_us, last_write,
                  output ready);
endinterface

@@ hdl/clcd_ucode_rom.sv @@
module clcd_ucode_rom (
  input  logic [clcd_pkg::UcAddrW-1:0] pc_i,
  output clcd_pkg::clcd_uword_t        uword_o
);

  // program: initialise at the start, generic byte send after it
  always_comb begin
    unique case (pc_i)
      // power-up settle with backlight on
      6'd0:  uword_o = clcd_pkg::uw(clcd_pkg::NIB_CONST, 4'h0, 1'b0, clcd_pkg::WAIT_POWER,
                                    1'b0, 1'b0, '0);
      // wake nibbles 3, 3, 3 then 2 for four-bit mode
      6'd1:  uword_o = clcd_pkg::uw(clcd_pkg::NIB_CONST, 4'h3, 1'b0, clcd_pkg::WAIT_SHORT,
                                    1'b0, 1'b0, '0);
      6'd2:  uword_o = clcd_pkg::uw(clcd_pkg::NIB_CONST, 4'h3, 1'b1, clcd_pkg::WAIT_SHORT,
                                    1'b0, 1'b0, '0);
      6'd3:  uword_o = clcd_pkg::uw(clcd_pkg::NIB_CONST, 4'h3, 1'b0, clcd_pkg::WAIT_WAKE,
                                    1'b0, 1'b0, '0);
      6'd4:  uword_o = clcd_pkg::uw(clcd_pkg::NIB_CONST, 4'h3, 1'b0, clcd_pkg::WAIT_SHORT,
                                    1'b0, 1'b0, '0);
      6'd5:  uword_o = clcd_pkg::uw(clcd_pkg::NIB_CONST, 4'h3, 1'b1, clcd_pkg::WAIT_SHORT,
                                    1'b0, 1'b0, '0);
      6'd6:  uword_o = clcd_pkg::uw(clcd_pkg::NIB_CONST, 4'h3, 1'b0, clcd_pkg::WAIT_CMD,
                                    1'b0, 1'b0, '0);
      6'd7:  uword_o = clcd_pkg::uw(clcd_pkg::NIB_CONST, 4'h3, 1'b0, clcd_pkg::WAIT_SHORT,
                                    1'b0, 1'b0, '0);
      6'd8:  uword_o = clcd_pkg::uw(clcd_pkg::NIB_CONST, 4'h3, 1'b1, clcd_pkg::WAIT_SHORT,
                                    1'b0, 1'b0, '0);
      6'd9:  uword_o = clcd_pkg::uw(clcd_pkg::NIB_CONST, 4'h3, 1'b0, clcd_pkg::WAIT_CMD,
                                    1'b0, 1'b0, '0);
      6'd10: uword_o = clcd_pkg::uw(clcd_pkg::NIB_CONST, 4'h2, 1'b0, clcd_pkg::WAIT_SHORT,
                                    1'b0, 1'b0, '0);
      6'd11: uword_o = clcd_pkg::uw(clcd_pkg::NIB_CONST, 4'h2, 1'b1, clcd_pkg::WAIT_SHORT,
                                    1'b0, 1'b0, '0);
      6'd12: uword_o = clcd_pkg::uw(clcd_pkg::NIB_CONST, 4'h2, 1'b0, clcd_pkg::WAIT_CMD,
                                    1'b0, 1'b0, '0);
      // function set, two lines
      6'd13: uword_o = clcd_pkg::uw(clcd_pkg::NIB_CONST, 4'h2, 1'b0, clcd_pkg::WAIT_SHORT,
                                    1'b0, 1'b0, '0);
      6'd14: uword_o = clcd_pkg::uw(clcd_pkg::NIB_CONST, 4'h2, 1'b1, clcd_pkg::WAIT_SHORT,
                                    1'b0, 1'b0, '0);
      6'd15: uword_o = clcd_pkg::uw(clcd_pkg::NIB_CONST, 4'h2, 1'b0, clcd_pkg::WAIT_EXEC,
                                    1'b0, 1'b0, '0);
      6'd16: uword_o = clcd_pkg::uw(clcd_pkg::NIB_CONST, 4'h8, 1'b0, clcd_pkg::WAIT_SHORT,
                                    1'b0, 1'b0, '0);
      6'd17: uword_o = clcd_pkg::uw(clcd_pkg::NIB_CONST, 4'h8, 1'b1, clcd_pkg::WAIT_SHORT,
                                    1'b0, 1'b0, '0);
      6'd18: uword_o = clcd_pkg::uw(clcd_pkg::NIB_CONST, 4'h8, 1'b0, clcd_pkg::WAIT_EXEC,
                                    1'b0, 1'b0, '0);
      // display on, cursor off
      6'd19: uword_o = clcd_pkg::uw(clcd_pkg::NIB_CONST, 4'h0, 1'b0, clcd_pkg::WAIT_SHORT,
                                    1'b0, 1'b0, '0);
      6'd20: uword_o = clcd_pkg::uw(clcd_pkg::NIB_CONST, 4'h0, 1'b1, clcd_pkg::WAIT_SHORT,
                                    1'b0, 1'b0, '0);
      6'd21: uword_o = clcd_pkg::uw(clcd_pkg::NIB_CONST, 4'h0, 1'b0, clcd_pkg::WAIT_EXEC,
                                    1'b0, 1'b0, '0);
      6'd22: uword_o = clcd_pkg::uw(clcd_pkg::NIB_CONST, 4'hC, 1'b0, clcd_pkg::WAIT_SHORT,
                                    1'b0, 1'b0, '0);
      6'd23: uword_o = clcd_pkg::uw(clcd_pkg::NIB_CONST, 4'hC, 1'b1, clcd_pkg::WAIT_SHORT,
                                    1'b0, 1'b0, '0);
      6'd24: uword_o = clcd_pkg::uw(clcd_pkg::NIB_CONST, 4'hC, 1'b0, clcd_pkg::WAIT_EXEC,
                                    1'b0, 1'b0, '0);
      // clear display
      6'd25: uword_o = clcd_pkg::uw(clcd_pkg::NIB_CONST, 4'h0, 1'b0, clcd_pkg::WAIT_SHORT,
                                    1'b0, 1'b0, '0);
      6'd26: uword_o = clcd_pkg::uw(clcd_pkg::NIB_CONST, 4'h0, 1'b1, clcd_pkg::WAIT_SHORT,
                                    1'b0, 1'b0, '0);
      6'd27: uword_o = clcd_pkg::uw(clcd_pkg::NIB_CONST, 4'h0, 1'b0, clcd_pkg::WAIT_EXEC,
                                    1'b0, 1'b0, '0);
      6'd28: uword_o = clcd_pkg::uw(clcd_pkg::NIB_CONST, 4'h1, 1'b0, clcd_pkg::WAIT_SHORT,
                                    1'b0, 1'b0, '0);
      6'd29: uword_o = clcd_pkg::uw(clcd_pkg::NIB_CONST, 4'h1, 1'b1, clcd_pkg::WAIT_SHORT,
                                    1'b0, 1'b0, '0);
      6'd30: uword_o = clcd_pkg::uw(clcd_pkg::NIB_CONST, 4'h1, 1'b0, clcd_pkg::WAIT_CLEAR,
                                    1'b0, 1'b0, '0);
      // entry mode, increment
      6'd31: uword_o = clcd_pkg::uw(clcd_pkg::NIB_CONST, 4'h0, 1'b0, clcd_pkg::WAIT_SHORT,
                                    1'b0, 1'b0, '0);
      6'd32: uword_o = clcd_pkg::uw(clcd_pkg::NIB_CONST, 4'h0, 1'b1, clcd_pkg::WAIT_SHORT,
                                    1'b0, 1'b0, '0);
      6'd33: uword_o = clcd_pkg::uw(clcd_pkg::NIB_CONST, 4'h0, 1'b0, clcd_pkg::WAIT_EXEC,
                                    1'b0, 1'b0, '0);
      6'd34: uword_o = clcd_pkg::uw(clcd_pkg::NIB_CONST, 4'h6, 1'b0, clcd_pkg::WAIT_SHORT,
                                    1'b0, 1'b0, '0);
      6'd35: uword_o = clcd_pkg::uw(clcd_pkg::NIB_CONST, 4'h6, 1'b1, clcd_pkg::WAIT_SHORT,
                                    1'b0, 1'b0, '0);
      6'd36: uword_o = clcd_pkg::uw(clcd_pkg::NIB_CONST, 4'h6, 1'b0, clcd_pkg::WAIT_EXEC,
                                    1'b1, 1'b0, '0);
      // generic operand byte, clear takes the long closing wait
      6'd37: uword_o = clcd_pkg::uw(clcd_pkg::NIB_OP_HI, 4'h0, 1'b0, clcd_pkg::WAIT_SHORT,
                                    1'b0, 1'b0, '0);
      6'd38: uword_o = clcd_pkg::uw(clcd_pkg::NIB_OP_HI, 4'h0, 1'b1, clcd_pkg::WAIT_SHORT,
                                    1'b0, 1'b0, '0);
      6'd39: uword_o = clcd_pkg::uw(clcd_pkg::NIB_OP_HI, 4'h0, 1'b0, clcd_pkg::WAIT_EXEC,
                                    1'b0, 1'b0, '0);
      6'd40: uword_o = clcd_pkg::uw(clcd_pkg::NIB_OP_LO, 4'h0, 1'b0, clcd_pkg::WAIT_SHORT,
                                    1'b0, 1'b0, '0);
      6'd41: uword_o = clcd_pkg::uw(clcd_pkg::NIB_OP_LO, 4'h0, 1'b1, clcd_pkg::WAIT_SHORT,
                                    1'b0, 1'b1, clcd_pkg::StepLastClear);
      6'd42: uword_o = clcd_pkg::uw(clcd_pkg::NIB_OP_LO, 4'h0, 1'b0, clcd_pkg::WAIT_EXEC,
                                    1'b1, 1'b0, '0);
      6'd43: uword_o = clcd_pkg::uw(clcd_pkg::NIB_OP_LO, 4'h0, 1'b0, clcd_pkg::WAIT_CLEAR,
                                    1'b1, 1'b0, '0);
      // unused addresses end the program
      default: uword_o = clcd_pkg::uw(clcd_pkg::NIB_CONST, 4'h0, 1'b0,
                                      clcd_pkg::WAIT_SHORT, 1'b1, 1'b0, '0);
    endcase
  end

endmodule

@@ hdl/clcd_datapath.sv @@
module clcd_datapath (
  input  clcd_pkg::clcd_uword_t uword_i,
  input  logic [7:0]            operand_i,
  input  logic                  rs_i,
  output logic [7:0]            byte_o,
  output logic [15:0]           wait_o,
  output logic                  last_o
);

  logic [3:0] nib;

  // nibble select
  always_comb begin
    unique case (uword_i.nib_src)
      clcd_pkg::NIB_CONST: nib = uword_i.nib;
      clcd_pkg::NIB_OP_HI: nib = operand_i[7:4];
      clcd_pkg::NIB_OP_LO: nib = operand_i[3:0];
      default:             nib = uword_i.nib;
    endcase
  end

  // expander byte: data nibble, backlight on, enable, rw low, rs
  assign byte_o = {nib, 1'b1, uword_i.en, 1'b0, rs_i};
  assign wait_o = clcd_pkg::wait_us(uword_i.wait_sel);
  assign last_o = uword_i.last;

endmodule

@@ hdl/char_lcd_i2c_expander_sequencer.sv @@
// a taken item loads the step counter; its first write is registered as the counter advances
// throughput: one write per cycle while wr_o is ready; initialise issues 37 writes,
//   every other request 6, set by the microcode step counter issuing one control word per cycle
// the next item is taken in the cycle the final write of the current one is issued
// reset: asynchronous, active low; sequencer idle, no write pending, bus address 39
module char_lcd_i2c_expander_sequencer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [6:0]         cfg_wdata_i,
  clcd_req_if.sink           req_i,
  clcd_wr_if.source          wr_o
);

  logic                          busy_q;
  logic [clcd_pkg::UcAddrW-1:0]  pc_q, pc_d;
  logic [1:0]                    type_q;
  logic [7:0]                    operand_q, operand_d;
  logic [6:0]                    addr_q;
  logic                          out_valid_q;
  logic [7:0]                    out_byte_q;
  logic [6:0]                    out_addr_q;
  logic [15:0]                   out_wait_q;
  logic                          out_last_q;

  clcd_pkg::clcd_uword_t         uword;
  logic [7:0]                    dp_byte;
  logic [15:0]                   dp_wait;
  logic                          dp_last;
  logic                          accept, advance, is_clear, rs;
  logic [3:0]                    col_clamped;
  logic [clcd_pkg::UcAddrW-1:0]  entry;

  // handshake
  assign advance     = busy_q && (!out_valid_q || wr_o.ready);
  assign req_i.ready = !busy_q || (advance && uword.last);
  assign accept      = req_i.valid && req_i.ready;

  // bus address register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= 7'd39;
    end else if (cfg_we_i) begin
      addr_q <= cfg_wdata_i;
    end
  end

  // operand for the request
  assign col_clamped = (req_i.column > clcd_pkg::ColMax) ? clcd_pkg::ColMax[3:0]
                                                          : req_i.column[3:0];
  always_comb begin
    unique case (clcd_pkg::clcd_req_e'(req_i.req_type))
      clcd_pkg::REQ_INIT:   operand_d = '0;
      clcd_pkg::REQ_CLEAR:  operand_d = clcd_pkg::CmdClear;
      clcd_pkg::REQ_CURSOR: operand_d = clcd_pkg::CmdSetDdram
                                      | ((req_i.row_index != 8'd0) ? clcd_pkg::RowOffset
                                                                   : 8'h00)
                                      | {4'h0, col_clamped};
      clcd_pkg::REQ_CHAR:   operand_d = req_i.char_code;
      default:              operand_d = req_i.char_code;
    endcase
  end

  assign entry = (clcd_pkg::clcd_req_e'(req_i.req_type) == clcd_pkg::REQ_INIT)
               ? clcd_pkg::EntryInit : clcd_pkg::EntryByte;

  // held request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_q    <= '0;
      operand_q <= '0;
    end else if (accept) begin
      type_q    <= req_i.req_type;
      operand_q <= operand_d;
    end
  end

  assign is_clear = clcd_pkg::clcd_req_e'(type_q) == clcd_pkg::REQ_CLEAR;
  assign rs       = clcd_pkg::clcd_req_e'(type_q) == clcd_pkg::REQ_CHAR;

  // microcode table and datapath
  clcd_ucode_rom u_rom (
    .pc_i    (pc_q),
    .uword_o (uword)
  );

  clcd_datapath u_dp (
    .uword_i   (uword),
    .operand_i (operand_q),
    .rs_i      (rs),
    .byte_o    (dp_byte),
    .wait_o    (dp_wait),
    .last_o    (dp_last)
  );

  // next step: conditional jump on clear, else fall through
  assign pc_d = (uword.jmp_clear && is_clear) ? uword.jmp_tgt
                                              : pc_q + clcd_pkg::UcAddrW'(1);

  // step counter and busy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= '0;
    end else if (accept) begin
      busy_q <= 1'b1;
      pc_q   <= entry;
    end else if (advance) begin
      busy_q <= !uword.last;
      pc_q   <= pc_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (wr_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_byte_q <= dp_byte;
      out_addr_q <= addr_q;
      out_wait_q <= dp_wait;
      out_last_q <= dp_last;
    end
  end

  assign wr_o.valid          = out_valid_q;
  assign wr_o.expander_byte  = out_byte_q;
  assign wr_o.target_address = out_addr_q;
  assign wr_o.wait_after_us  = out_wait_q;
  assign wr_o.last_write     = out_last_q;

endmodule
